FILE: sv/nrr_pkg.sv
`default_nettype none

package nrr_pkg;

  localparam int MaxWidthDefault  = 512;
  localparam int MaxHeightDefault = 512;

  // command queue between front and back, and result queue at the output
  localparam int QueueDepth = 4;
  localparam int OutDepth   = 4;

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  typedef enum logic [1:0] {
    RegFrameWidth  = 2'd0,
    RegFrameHeight = 2'd1,
    RegRotation    = 2'd2,
    RegMirror      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    RotNone         = 2'd0,
    RotQuarter      = 2'd1,
    RotHalf         = 2'd2,
    RotThreeQuarter = 2'd3
  } rot_e;

  typedef enum logic {
    OpWrite = 1'b0,
    OpRead  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KindRead   = 3'd0,
    KindLumaWr = 3'd1,
    KindUWr    = 3'd2,
    KindVWr    = 3'd3,
    KindError  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    StatusPixel = 2'd0,
    StatusWrite = 2'd1,
    StatusError = 2'd2
  } status_e;

  typedef struct packed {
    logic [9:0] frame_width;
    logic [9:0] frame_height;
    rot_e       rotation_code;
    logic       mirror_enable;
  } cfg_t;

  localparam logic [9:0] WidthReset  = 10'd512;
  localparam logic [9:0] HeightReset = 10'd512;
  localparam cfg_t CfgReset = '{
    frame_width:   WidthReset,
    frame_height:  HeightReset,
    rotation_code: RotQuarter,
    mirror_enable: 1'b1
  };

  // BT.601 integer coefficients
  localparam logic signed [19:0] CoefY      = 20'sd298;
  localparam logic signed [19:0] CoefRv     = 20'sd409;
  localparam logic signed [19:0] CoefGu     = 20'sd100;
  localparam logic signed [19:0] CoefGv     = 20'sd208;
  localparam logic signed [19:0] CoefBu     = 20'sd516;
  localparam logic signed [19:0] RoundTerm  = 20'sd128;
  localparam logic signed [19:0] ChromaBias = 20'sd128;

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

FILE: sv/nrr_ram.sv
`default_nettype none

module nrr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int Aw = nrr_pkg::addr_bits(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/nrr_fifo.sv
`default_nettype none

module nrr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int Aw = nrr_pkg::addr_bits(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [Aw:0]      count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (Aw + 1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d    = do_push ? wr_q + 1'b1 : wr_q;
    rd_d    = do_pop ? rd_q + 1'b1 : rd_q;
    count_d = count_q + (Aw + 1)'(do_push) - (Aw + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/nrr_front.sv
`default_nettype none

module nrr_front #(
  parameter int MaxWidth  = nrr_pkg::MaxWidthDefault,
  parameter int MaxHeight = nrr_pkg::MaxHeightDefault,
  localparam int LumaAw   = nrr_pkg::addr_bits(MaxWidth * MaxHeight),
  localparam int ChromaAw = nrr_pkg::addr_bits(MaxWidth * MaxHeight / 4)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nrr_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic [18:0]          byte_addr_i,
  input  logic [7:0]           byte_value_i,
  input  logic [8:0]           out_col_i,
  input  logic [8:0]           out_row_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output nrr_pkg::kind_e       cmd_kind_o,
  output logic [LumaAw-1:0]    cmd_luma_addr_o,
  output logic [ChromaAw-1:0]  cmd_chroma_addr_o,
  output logic [7:0]           cmd_data_o
);

  localparam logic [19:0] PlaneReset =
    20'({10'd0, nrr_pkg::WidthReset} * {10'd0, nrr_pkg::HeightReset});
  localparam logic [20:0] Plane3hReset = {1'b0, PlaneReset} + {2'b0, PlaneReset[19:1]};

  logic [9:0] w, h, w_out, h_out, col10, row10, sx, sy;
  logic       size_ok, swap, rd_ok, is_luma, in_frame;
  logic [19:0] addr20, off;

  // frame plane size, follows the config registers
  logic [19:0] plane_q, plane_d;
  logic [20:0] plane3h_q, plane3h_d;
  // frame size the plane registers were computed from
  logic [9:0]  plane_w_q, plane_h_q;
  logic        plane_fresh;

  // stage A: classification and source coordinates
  logic                a_valid_q;
  nrr_pkg::kind_e      a_kind_q, a_kind_d;
  logic [9:0]          a_sx_q, a_sy_q;
  logic [18:0]         a_waddr_q, a_waddr_d;
  logic [7:0]          a_data_q;

  // stage B: store addresses
  logic                b_valid_q;
  nrr_pkg::kind_e      b_kind_q;
  logic [LumaAw-1:0]   b_luma_q, b_luma_d;
  logic [ChromaAw-1:0] b_chroma_q, b_chroma_d;
  logic [7:0]          b_data_q;

  logic [19:0] yi;
  logic [17:0] ci;
  logic        adv_a, adv_b;

  assign w = cfg_i.frame_width;
  assign h = cfg_i.frame_height;

  // input waits after a frame size change until the plane registers catch up
  assign plane_fresh = (plane_w_q == w) && (plane_h_q == h);

  assign adv_b      = !b_valid_q || cmd_ready_i;
  assign adv_a      = !a_valid_q || adv_b;
  assign in_ready_o = adv_a && plane_fresh;

  always_comb begin
    plane_d   = {10'd0, w} * {10'd0, h};
    plane3h_d = {1'b0, plane_d} + {2'b0, plane_d[19:1]};

    size_ok = (w >= 10'd2) && (32'(w) <= MaxWidth) && !w[0] &&
              (h >= 10'd2) && (32'(h) <= MaxHeight) && !h[0];

    swap  = (cfg_i.rotation_code == nrr_pkg::RotQuarter) ||
            (cfg_i.rotation_code == nrr_pkg::RotThreeQuarter);
    w_out = swap ? h : w;
    h_out = swap ? w : h;
    col10 = {1'b0, out_col_i};
    row10 = {1'b0, out_row_i};
    rd_ok = (col10 < w_out) && (row10 < h_out);

    case (cfg_i.rotation_code)
      nrr_pkg::RotNone: begin
        sx = col10;
        sy = row10;
      end
      nrr_pkg::RotQuarter: begin
        sx = row10;
        sy = col10;
      end
      nrr_pkg::RotHalf: begin
        sx = w - 10'd1 - col10;
        sy = h - 10'd1 - row10;
      end
      nrr_pkg::RotThreeQuarter: begin
        sx = row10;
        sy = h - 10'd1 - col10;
      end
      default: begin
        sx = col10;
        sy = row10;
      end
    endcase
    if (cfg_i.mirror_enable) begin
      sx = w - 10'd1 - sx;
    end

    addr20   = {1'b0, byte_addr_i};
    is_luma  = addr20 < plane_q;
    in_frame = {1'b0, addr20} < plane3h_q;
    off      = addr20 - plane_q;

    a_waddr_d = is_luma ? byte_addr_i : off[19:1];

    if (!size_ok) begin
      a_kind_d = nrr_pkg::KindError;
    end else if (op_i == nrr_pkg::OpRead) begin
      a_kind_d = rd_ok ? nrr_pkg::KindRead : nrr_pkg::KindError;
    end else if (is_luma) begin
      a_kind_d = nrr_pkg::KindLumaWr;
    end else if (in_frame) begin
      a_kind_d = off[0] ? nrr_pkg::KindVWr : nrr_pkg::KindUWr;
    end else begin
      a_kind_d = nrr_pkg::KindError;
    end
  end

  always_comb begin
    yi = {10'd0, a_sy_q} * {10'd0, w} + {10'd0, a_sx_q};
    ci = {9'd0, a_sy_q[9:1]} * {9'd0, w[9:1]} + {9'd0, a_sx_q[9:1]};
    if (a_kind_q == nrr_pkg::KindRead) begin
      b_luma_d   = LumaAw'(yi);
      b_chroma_d = ChromaAw'(ci);
    end else begin
      b_luma_d   = LumaAw'(a_waddr_q);
      b_chroma_d = ChromaAw'(a_waddr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      plane_q   <= PlaneReset;
      plane3h_q <= Plane3hReset;
      plane_w_q <= nrr_pkg::WidthReset;
      plane_h_q <= nrr_pkg::HeightReset;
    end else begin
      plane_q   <= plane_d;
      plane3h_q <= plane3h_d;
      plane_w_q <= w;
      plane_h_q <= h;
      if (adv_a) begin
        a_valid_q <= in_valid_i && plane_fresh;
      end
      if (adv_b) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      a_kind_q  <= a_kind_d;
      a_sx_q    <= sx;
      a_sy_q    <= sy;
      a_waddr_q <= a_waddr_d;
      a_data_q  <= byte_value_i;
    end
    if (adv_b) begin
      b_kind_q   <= a_kind_q;
      b_luma_q   <= b_luma_d;
      b_chroma_q <= b_chroma_d;
      b_data_q   <= a_data_q;
    end
  end

  assign cmd_valid_o       = b_valid_q;
  assign cmd_kind_o        = b_kind_q;
  assign cmd_luma_addr_o   = b_luma_q;
  assign cmd_chroma_addr_o = b_chroma_q;
  assign cmd_data_o        = b_data_q;

endmodule

`default_nettype wire

FILE: sv/nrr_back.sv
`default_nettype none

module nrr_back #(
  parameter int MaxWidth  = nrr_pkg::MaxWidthDefault,
  parameter int MaxHeight = nrr_pkg::MaxHeightDefault,
  localparam int LumaDepth   = MaxWidth * MaxHeight,
  localparam int ChromaDepth = (LumaDepth / 4 > 0) ? LumaDepth / 4 : 1,
  localparam int LumaAw      = nrr_pkg::addr_bits(LumaDepth),
  localparam int ChromaAw    = nrr_pkg::addr_bits(ChromaDepth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  nrr_pkg::kind_e      cmd_kind_i,
  input  logic [LumaAw-1:0]   cmd_luma_addr_i,
  input  logic [ChromaAw-1:0] cmd_chroma_addr_i,
  input  logic [7:0]          cmd_data_i,
  output logic                out_push_o,
  output logic [15:0]         out_rgb_o,
  output nrr_pkg::status_e    out_status_o,
  input  logic                out_pop_i
);

  localparam int CreditW = $clog2(nrr_pkg::OutDepth + 1);

  logic [CreditW-1:0] credits_q, credits_d;
  logic pop, is_read;
  logic [7:0] y_rdata, u_rdata, v_rdata;

  logic             v1_q, v2_q;
  nrr_pkg::status_e st1_q, st1_d, st2_q;
  logic signed [19:0] y_w, u_w, v_w;
  logic signed [19:0] ty_q, trv_q, tgu_q, tgv_q, tbu_q;
  logic signed [19:0] r_sum, g_sum, b_sum;
  logic [7:0] r8, g8, b8;

  function automatic logic [7:0] clamp8(input logic signed [19:0] s);
    logic [7:0] c;
    if (s[19]) begin
      c = 8'd0;
    end else if (s[18:16] != 3'd0) begin
      c = 8'hFF;
    end else begin
      c = s[15:8];
    end
    return c;
  endfunction

  // a command leaves the queue only when its result has a guaranteed slot downstream
  assign pop       = cmd_valid_i && (credits_q != '0);
  assign cmd_pop_o = pop;
  assign is_read   = (cmd_kind_i == nrr_pkg::KindRead);

  nrr_ram #(.Width(8), .Depth(LumaDepth)) u_luma (
    .clk_i   (clk_i),
    .en_i    (pop && (is_read || cmd_kind_i == nrr_pkg::KindLumaWr)),
    .we_i    (cmd_kind_i == nrr_pkg::KindLumaWr),
    .addr_i  (cmd_luma_addr_i),
    .wdata_i (cmd_data_i),
    .rdata_o (y_rdata)
  );

  nrr_ram #(.Width(8), .Depth(ChromaDepth)) u_chroma_u (
    .clk_i   (clk_i),
    .en_i    (pop && (is_read || cmd_kind_i == nrr_pkg::KindUWr)),
    .we_i    (cmd_kind_i == nrr_pkg::KindUWr),
    .addr_i  (cmd_chroma_addr_i),
    .wdata_i (cmd_data_i),
    .rdata_o (u_rdata)
  );

  nrr_ram #(.Width(8), .Depth(ChromaDepth)) u_chroma_v (
    .clk_i   (clk_i),
    .en_i    (pop && (is_read || cmd_kind_i == nrr_pkg::KindVWr)),
    .we_i    (cmd_kind_i == nrr_pkg::KindVWr),
    .addr_i  (cmd_chroma_addr_i),
    .wdata_i (cmd_data_i),
    .rdata_o (v_rdata)
  );

  always_comb begin
    case (cmd_kind_i)
      nrr_pkg::KindRead:   st1_d = nrr_pkg::StatusPixel;
      nrr_pkg::KindLumaWr,
      nrr_pkg::KindUWr,
      nrr_pkg::KindVWr:    st1_d = nrr_pkg::StatusWrite;
      default:             st1_d = nrr_pkg::StatusError;
    endcase
    credits_d = credits_q - CreditW'(pop) + CreditW'(out_pop_i);
  end

  always_comb begin
    y_w = signed'({12'd0, y_rdata});
    u_w = signed'({12'd0, u_rdata}) - nrr_pkg::ChromaBias;
    v_w = signed'({12'd0, v_rdata}) - nrr_pkg::ChromaBias;
  end

  always_comb begin
    r_sum = ty_q + trv_q;
    g_sum = ty_q - tgu_q - tgv_q;
    b_sum = ty_q + tbu_q;
    r8    = clamp8(r_sum);
    g8    = clamp8(g_sum);
    b8    = clamp8(b_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credits_q <= CreditW'(nrr_pkg::OutDepth);
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
    end else begin
      credits_q <= credits_d;
      v1_q      <= pop;
      v2_q      <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q <= st1_d;
    st2_q <= st1_q;
    ty_q  <= y_w * nrr_pkg::CoefY + nrr_pkg::RoundTerm;
    trv_q <= v_w * nrr_pkg::CoefRv;
    tgu_q <= u_w * nrr_pkg::CoefGu;
    tgv_q <= v_w * nrr_pkg::CoefGv;
    tbu_q <= u_w * nrr_pkg::CoefBu;
  end

  assign out_push_o   = v2_q;
  assign out_status_o = st2_q;
  assign out_rgb_o    = (st2_q == nrr_pkg::StatusPixel) ? {r8[7:3], g8[7:2], b8[7:3]} : 16'd0;

endmodule

`default_nettype wire

FILE: sv/nv12_to_rgb565_rotate.sv
// NV12 frame store with RGB565 readout under rotation and mirror.
//
// Input stream (s_axis): tuser is the op (0 store one frame byte, 1 read one
// output pixel); tdata carries the byte address, byte value and output column
// and row. Output stream (m_axis): one result per input, in order; tdata is the
// RGB565 pixel (zero for writes and errors), tuser the status (0 pixel,
// 1 write done, 2 address or coordinate out of range).
// Frame size, rotation and mirror are set over the APB port; the user is to
// keep the stream idle meanwhile; the block does not enforce it. s_axis_tready
// drops for one clock after a frame size write. Throughput is one transaction
// per clock while m_axis keeps up: luma and the two chroma bytes sit in
// separate single-port RAMs, each touched once per transaction. A transaction
// passes two front stages (classify, then one address multiply), a 4-entry
// command queue, the RAM read, the coefficient multiply and the clamp/pack
// into the output queue. When m_axis stalls, results collect in a 4-entry
// output queue; the back end issues a command only when an output slot is
// reserved for it, and the command queue then fills until s_axis_tready drops.
// Reset restores 512x512, transpose rotation, mirror on, and empties both
// queues; the frame stores are not cleared and hold nothing defined until
// written.
`default_nettype none

module nv12_to_rgb565_rotate #(
  parameter int MaxWidth  = nrr_pkg::MaxWidthDefault,
  parameter int MaxHeight = nrr_pkg::MaxHeightDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [18:0] byte_addr, [26:19] byte_value, [35:27] out_col, [44:36] out_row
  input  logic [47:0]                   s_axis_tdata,
  // [0] op
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] rgb565
  output logic [15:0]                   m_axis_tdata,
  // [1:0] status
  output logic [1:0]                    m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nrr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [nrr_pkg::CfgDataW-1:0]  pwdata,
  output logic [nrr_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int LumaDepth   = MaxWidth * MaxHeight;
  localparam int ChromaDepth = (LumaDepth / 4 > 0) ? LumaDepth / 4 : 1;
  localparam int LumaAw      = nrr_pkg::addr_bits(LumaDepth);
  localparam int ChromaAw    = nrr_pkg::addr_bits(ChromaDepth);
  localparam int CmdW        = 3 + LumaAw + ChromaAw + 8;
  localparam int ResW        = 2 + 16;

  nrr_pkg::cfg_t    cfg_q;
  nrr_pkg::reg_idx_e reg_idx;

  logic                cmd_valid, cmd_full, cmd_empty, cmd_pop;
  nrr_pkg::kind_e      cmd_kind;
  logic [LumaAw-1:0]   cmd_luma;
  logic [ChromaAw-1:0] cmd_chroma;
  logic [7:0]          cmd_data;
  logic [CmdW-1:0]     cmd_wdata, cmd_rdata;

  logic             res_push, res_empty, res_full, res_pop;
  logic [15:0]      res_rgb;
  nrr_pkg::status_e res_status;
  logic [ResW-1:0]  res_rdata;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = nrr_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= nrr_pkg::CfgReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        nrr_pkg::RegFrameWidth:  cfg_q.frame_width   <= pwdata[9:0];
        nrr_pkg::RegFrameHeight: cfg_q.frame_height  <= pwdata[9:0];
        nrr_pkg::RegRotation:    cfg_q.rotation_code <= nrr_pkg::rot_e'(pwdata[1:0]);
        nrr_pkg::RegMirror:      cfg_q.mirror_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nrr_pkg::RegFrameWidth:  prdata = {22'd0, cfg_q.frame_width};
      nrr_pkg::RegFrameHeight: prdata = {22'd0, cfg_q.frame_height};
      nrr_pkg::RegRotation:    prdata = {30'd0, cfg_q.rotation_code};
      nrr_pkg::RegMirror:      prdata = {31'd0, cfg_q.mirror_enable};
      default:                 prdata = '0;
    endcase
  end

  nrr_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .op_i              (s_axis_tuser),
    .byte_addr_i       (s_axis_tdata[18:0]),
    .byte_value_i      (s_axis_tdata[26:19]),
    .out_col_i         (s_axis_tdata[35:27]),
    .out_row_i         (s_axis_tdata[44:36]),
    .cmd_valid_o       (cmd_valid),
    .cmd_ready_i       (!cmd_full),
    .cmd_kind_o        (cmd_kind),
    .cmd_luma_addr_o   (cmd_luma),
    .cmd_chroma_addr_o (cmd_chroma),
    .cmd_data_o        (cmd_data)
  );

  assign cmd_wdata = {cmd_kind, cmd_luma, cmd_chroma, cmd_data};

  nrr_fifo #(.Width(CmdW), .Depth(nrr_pkg::QueueDepth)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .wdata_i (cmd_wdata),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  nrr_back #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (!cmd_empty),
    .cmd_pop_o         (cmd_pop),
    .cmd_kind_i        (nrr_pkg::kind_e'(cmd_rdata[CmdW-1 -: 3])),
    .cmd_luma_addr_i   (cmd_rdata[8 + ChromaAw +: LumaAw]),
    .cmd_chroma_addr_i (cmd_rdata[8 +: ChromaAw]),
    .cmd_data_i        (cmd_rdata[7:0]),
    .out_push_o        (res_push),
    .out_rgb_o         (res_rgb),
    .out_status_o      (res_status),
    .out_pop_i         (res_pop)
  );

  assign res_pop = m_axis_tvalid && m_axis_tready;

  nrr_fifo #(.Width(ResW), .Depth(nrr_pkg::OutDepth)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i ({res_status, res_rgb}),
    .pop_i   (res_pop),
    .rdata_o (res_rdata),
    .full_o  (res_full),
    .empty_o (res_empty)
  );

  // credits in the back end keep the result queue from overflowing
  assign m_axis_tvalid = !res_empty || (res_full && !res_empty);
  assign m_axis_tdata  = res_rdata[15:0];
  assign m_axis_tuser  = res_rdata[17:16];

endmodule

`default_nettype wire

FILE: sv/nrr_checker.sv
`default_nettype none

module nrr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // two front stages, the command queue and the credited back end
  localparam int MaxInFlight = 2 + nrr_pkg::QueueDepth + nrr_pkg::OutDepth;

  logic [7:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 8'd0)
    else $error("result offered with no transaction outstanding");

  a_bounded_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q <= 8'(MaxInFlight)) &&
    ((pending_q != 8'(MaxInFlight)) || !s_axis_tready))
    else $error("more transactions in flight than the block can hold");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_zero_pixel_on_non_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != nrr_pkg::StatusPixel) |->
      (m_axis_tdata == 16'd0) &&
      ((m_axis_tuser == nrr_pkg::StatusWrite) || (m_axis_tuser == nrr_pkg::StatusError)))
    else $error("write or error result with bad status or nonzero pixel");

endmodule

bind nv12_to_rgb565_rotate nrr_checker u_nrr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int LumaDepth  = nrr_pkg::MaxWidthDefault * nrr_pkg::MaxHeightDefault;
  localparam int ChromaDepth = LumaDepth / 4;
  localparam int LongHold   = 200;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    nrr_pkg::op_e op;
    logic [18:0]  addr;
    logic [7:0]   value;
    logic [8:0]   col;
    logic [8:0]   row;
  } frame_item_t;

  typedef struct packed {
    logic [15:0]      rgb565;
    nrr_pkg::status_e status;
  } pixel_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [nrr_pkg::CfgAddrW-1:0] paddr = '0;
  logic [nrr_pkg::CfgDataW-1:0] pwdata = '0;
  logic [nrr_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  nv12_to_rgb565_rotate DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // register settings, shared by the generator and the predictor (only changed while idle)
  nrr_pkg::cfg_t frame_cfg = nrr_pkg::CfgReset;

  // predictor copy of the frame stores
  logic [7:0] luma_mem [LumaDepth];
  logic [7:0] cb_mem [ChromaDepth];
  logic [7:0] cr_mem [ChromaDepth];

  // entries the generated stream has written so far
  bit luma_set [LumaDepth];
  bit cb_set [ChromaDepth];
  bit cr_set [ChromaDepth];

  frame_item_t   stream_items_q[$];
  pixel_status_t pixel_status_q[$];
  frame_item_t   offered_item;

  int items_queued = 0;
  int results_checked = 0;
  int fail_count = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_ticket = 0;
  int hold_taken = 0;
  int sink_hold_left = 0;
  int cycle_count = 0;

  function automatic bit frame_ok(nrr_pkg::cfg_t c);
    int w, h;
    w = int'(c.frame_width);
    h = int'(c.frame_height);
    return w >= 2 && w <= nrr_pkg::MaxWidthDefault && w % 2 == 0 &&
           h >= 2 && h <= nrr_pkg::MaxHeightDefault && h % 2 == 0;
  endfunction

  function automatic void out_dims(nrr_pkg::cfg_t c, output int wo, output int ho);
    if (c.rotation_code == nrr_pkg::RotQuarter ||
        c.rotation_code == nrr_pkg::RotThreeQuarter) begin
      wo = int'(c.frame_height);
      ho = int'(c.frame_width);
    end else begin
      wo = int'(c.frame_width);
      ho = int'(c.frame_height);
    end
  endfunction

  function automatic void source_pixel(nrr_pkg::cfg_t c, int col, int row,
                                       output int sx, output int sy);
    int w, h;
    w = int'(c.frame_width);
    h = int'(c.frame_height);
    case (c.rotation_code)
      nrr_pkg::RotQuarter: begin
        sx = row;
        sy = col;
      end
      nrr_pkg::RotHalf: begin
        sx = w - 1 - col;
        sy = h - 1 - row;
      end
      nrr_pkg::RotThreeQuarter: begin
        sx = row;
        sy = h - 1 - col;
      end
      default: begin
        sx = col;
        sy = row;
      end
    endcase
    if (c.mirror_enable) sx = w - 1 - sx;
  endfunction

  function automatic logic [7:0] limit_to_byte(int sum);
    if (sum < 0) return 8'd0;
    if ((sum >>> 8) > 255) return 8'd255;
    return 8'(sum >>> 8);
  endfunction

  function automatic logic [15:0] yuv_to_rgb565(logic [7:0] yb, logic [7:0] ub, logic [7:0] vb);
    int y, u, v;
    logic [7:0] r, g, b;
    y = int'(yb);
    u = int'(ub) - 128;
    v = int'(vb) - 128;
    r = limit_to_byte(298 * y + 409 * v + 128);
    g = limit_to_byte(298 * y - 100 * u - 208 * v + 128);
    b = limit_to_byte(298 * y + 516 * u + 128);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // applies one transaction to the predictor stores and returns its result
  function automatic pixel_status_t nv12_step(frame_item_t it);
    pixel_status_t res;
    int w, h, plane, a, off, wo, ho, sx, sy, li, ci;
    w = int'(frame_cfg.frame_width);
    h = int'(frame_cfg.frame_height);
    res.rgb565 = '0;
    res.status = nrr_pkg::StatusError;
    if (!frame_ok(frame_cfg)) return res;
    if (it.op == nrr_pkg::OpWrite) begin
      plane = w * h;
      a = int'(it.addr);
      if (a < plane) begin
        luma_mem[a] = it.value;
      end else if (a - plane < plane / 2) begin
        off = a - plane;
        if (off % 2 == 1) cr_mem[off / 2] = it.value;
        else cb_mem[off / 2] = it.value;
      end else begin
        return res;
      end
      res.status = nrr_pkg::StatusWrite;
      return res;
    end
    out_dims(frame_cfg, wo, ho);
    if (int'(it.col) >= wo || int'(it.row) >= ho) return res;
    source_pixel(frame_cfg, int'(it.col), int'(it.row), sx, sy);
    li = sy * w + sx;
    ci = (sy / 2) * (w / 2) + sx / 2;
    res.rgb565 = yuv_to_rgb565(luma_mem[li], cb_mem[ci], cr_mem[ci]);
    res.status = nrr_pkg::StatusPixel;
    return res;
  endfunction

  // input side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) pixel_status_q.push_back(nv12_step(offered_item));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stream_items_q.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          offered_item = stream_items_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {3'b000, offered_item.row, offered_item.col,
                           offered_item.value, offered_item.addr};
          s_axis_tuser <= offered_item.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, armed from the stimulus
  always @(posedge clk_i) begin
    if (hold_ticket != hold_taken) begin
      hold_taken <= hold_ticket;
      sink_hold_left <= LongHold;
    end else if (sink_hold_left > 0) begin
      sink_hold_left <= sink_hold_left - 1;
    end
  end

  // output side
  always @(posedge clk_i) begin
    pixel_status_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_status_q.size() == 0) begin
          $error("unexpected result: rgb565 %h status %0d", m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          exp_res = pixel_status_q.pop_front();
          results_checked++;
          if (m_axis_tdata !== exp_res.rgb565) begin
            $error("rgb565 mismatch: expected %h, actual %h", exp_res.rgb565, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_res.status, m_axis_tuser);
            fail_count++;
          end
        end
      end
      if (sink_hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_item(nrr_pkg::op_e op, int addr, int value, int col, int row);
    frame_item_t it;
    it.op = op;
    it.addr = addr[18:0];
    it.value = value[7:0];
    it.col = col[8:0];
    it.row = row[8:0];
    stream_items_q.push_back(it);
    items_queued++;
  endtask

  task automatic put_byte(int addr, int value);
    int plane, off;
    if (frame_ok(frame_cfg)) begin
      plane = int'(frame_cfg.frame_width) * int'(frame_cfg.frame_height);
      if (addr < plane) begin
        luma_set[addr] = 1'b1;
      end else if (addr - plane < plane / 2) begin
        off = addr - plane;
        if (off % 2 == 1) cr_set[off / 2] = 1'b1;
        else cb_set[off / 2] = 1'b1;
      end
    end
    push_item(nrr_pkg::OpWrite, addr, value, $urandom_range(511, 0), $urandom_range(511, 0));
  endtask

  // writes Y, U, V of the source pixel where given (>= 0), where never written,
  // or now and then anyway, then reads the output pixel
  task automatic read_pixel(int col, int row, int y_val, int u_val, int v_val);
    int w, plane, sx, sy, li, ci;
    w = int'(frame_cfg.frame_width);
    plane = w * int'(frame_cfg.frame_height);
    source_pixel(frame_cfg, col, row, sx, sy);
    li = sy * w + sx;
    ci = (sy / 2) * (w / 2) + sx / 2;
    if (y_val >= 0 || !luma_set[li] || $urandom_range(3, 0) == 0)
      put_byte(li, y_val >= 0 ? y_val : $urandom_range(255, 0));
    if (u_val >= 0 || !cb_set[ci] || $urandom_range(3, 0) == 0)
      put_byte(plane + 2 * ci, u_val >= 0 ? u_val : $urandom_range(255, 0));
    if (v_val >= 0 || !cr_set[ci] || $urandom_range(3, 0) == 0)
      put_byte(plane + 2 * ci + 1, v_val >= 0 ? v_val : $urandom_range(255, 0));
    push_item(nrr_pkg::OpRead, $urandom_range(524287, 0), $urandom_range(255, 0), col, row);
  endtask

  task automatic random_items(int n);
    int stop, wo, ho, col, row, plane, pick;
    stop = items_queued + n;
    out_dims(frame_cfg, wo, ho);
    plane = int'(frame_cfg.frame_width) * int'(frame_cfg.frame_height);
    while (items_queued < stop) begin
      pick = $urandom_range(99, 0);
      col = $urandom_range(511, 0);
      row = $urandom_range(511, 0);
      if (!frame_ok(frame_cfg)) begin
        // nothing gets stored here, so anything goes
        push_item(nrr_pkg::op_e'($urandom_range(1, 0)), $urandom_range(524287, 0),
                  $urandom_range(255, 0), col, row);
      end else if (pick < 60) begin
        read_pixel(col % wo, row % ho, -1, -1, -1);
      end else if (pick < 75) begin
        put_byte($urandom_range(plane * 3 / 2 - 1, 0), $urandom_range(255, 0));
      end else if (pick < 85) begin
        if (col < wo && row < ho) read_pixel(col, row, -1, -1, -1);
        else push_item(nrr_pkg::OpRead, $urandom_range(524287, 0),
                       $urandom_range(255, 0), col, row);
      end else begin
        put_byte($urandom_range(524287, 0), $urandom_range(255, 0));
      end
    end
  endtask

  task automatic wait_drained();
    while (items_queued != results_checked) @(posedge clk_i);
  endtask

  task automatic write_reg(nrr_pkg::reg_idx_e idx, int value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      nrr_pkg::RegFrameWidth:  frame_cfg.frame_width = value[9:0];
      nrr_pkg::RegFrameHeight: frame_cfg.frame_height = value[9:0];
      nrr_pkg::RegRotation:    frame_cfg.rotation_code = nrr_pkg::rot_e'(value[1:0]);
      nrr_pkg::RegMirror:      frame_cfg.mirror_enable = value[0];
      default: ;
    endcase
  endtask

  task automatic set_frame(int w, int h, nrr_pkg::rot_e rot, bit mir, int src_pct, int snk_pct);
    wait_drained();
    write_reg(nrr_pkg::RegFrameWidth, w);
    write_reg(nrr_pkg::RegFrameHeight, h);
    write_reg(nrr_pkg::RegRotation, int'(rot));
    write_reg(nrr_pkg::RegMirror, int'(mir));
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: 512x512, transpose, mirror
    read_pixel(0, 0, 0, 0, 0);
    read_pixel(511, 511, 255, 255, 255);
    read_pixel(0, 511, 255, 0, 255);
    read_pixel(511, 0, 16, 128, 128);
    put_byte(393215, 8'hff);
    put_byte(393216, 8'h00);
    put_byte(524287, 8'ha5);
    random_items(200);

    set_frame(2, 2, nrr_pkg::RotNone, 1'b0, 68, 0);
    put_byte(6, 8'h5a);
    push_item(nrr_pkg::OpRead, 0, 0, 2, 0);
    push_item(nrr_pkg::OpRead, 0, 0, 0, 511);
    random_items(140);

    set_frame(6, 4, nrr_pkg::RotQuarter, 1'b1, 0, 68);
    random_items(140);
    set_frame(8, 10, nrr_pkg::RotHalf, 1'b0, 27, 27);
    random_items(140);

    // output held off long enough for the block to back up into its input
    set_frame(4, 12, nrr_pkg::RotThreeQuarter, 1'b1, 0, 0);
    random_items(140);
    hold_ticket++;

    set_frame(512, 2, nrr_pkg::RotThreeQuarter, 1'b0, 68, 0);
    random_items(140);
    set_frame(2, 512, nrr_pkg::RotQuarter, 1'b0, 0, 68);
    random_items(140);

    // illegal frame sizes
    set_frame(1023, 8, nrr_pkg::RotHalf, 1'b1, 27, 27);
    random_items(40);
    set_frame(6, 0, nrr_pkg::RotNone, 1'b0, 0, 0);
    random_items(40);
    set_frame(514, 4, nrr_pkg::RotQuarter, 1'b1, 68, 0);
    random_items(40);
    set_frame(7, 8, nrr_pkg::RotNone, 1'b1, 0, 68);
    random_items(40);

    set_frame(512, 512, nrr_pkg::RotNone, 1'b1, 27, 27);
    random_items(140);
    set_frame(16, 14, nrr_pkg::RotHalf, 1'b1, 68, 0);
    random_items(140);
    set_frame(10, 6, nrr_pkg::RotNone, 1'b0, 0, 68);
    random_items(130);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
